### sv/sgt_pkg.sv
// ---------------------------------------------------------------------------
// sgt_pkg
// Shared constants, operation codes and helpers for the graph traversal block.
// ---------------------------------------------------------------------------
package sgt_pkg;

	localparam int MAX_NODES = 16;
	localparam int NODE_W    = 5;                         // node number field width
	localparam int IDX_W     = $clog2(MAX_NODES);         // row / stack index width
	localparam int DEPTH_W   = $clog2(MAX_NODES + 1);     // stack fill, 0..MAX_NODES

	typedef enum logic [1:0] {
		OP_ADD      = 2'd0,
		OP_TRAVERSE = 2'd1,
		OP_CLEAR    = 2'd2
	} op_e_t;

	// index of the lowest set bit (zero when none set)
	function automatic logic [IDX_W-1:0] low_index(input logic [MAX_NODES-1:0] v);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = MAX_NODES - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = IDX_W'(i);
			end
		end
		return r;
	endfunction

endpackage

### sv/stack_graph_traversal.sv
// ---------------------------------------------------------------------------
// stack_graph_traversal
// Directed graph held as an adjacency bit matrix in a RAM, with an iterative
// depth-first traversal driven by an explicit node stack in a second RAM.
// ---------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  in       | in_valid / in_ready  | operation, from_node, to_node
//  out      | out_valid / out_ready| visited_node, last
//  cfg      | cfg_wr_en            | cfg_wr_data (node_count)
//
//  Add edge reads the row, then writes it back; clear drops the row valid bits
//  in its accept step. Traverse of n reachable nodes runs from acceptance back
//  to idle through the accept step, then for each node a stack read, a row
//  read, a successor scan and an emit, plus a push step per successor on the
//  single stack write port (n-1 pushes in all).
//  One transaction is in flight at a time; in_ready is high only when idle.
//  Reset empties the graph through per-row valid bits, no clearing pass.
//  A full output register stalls the traversal at its emit step only.
//
module stack_graph_traversal
	import sgt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [NODE_W-1:0] cfg_wr_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        operation,
	input  logic [NODE_W-1:0] from_node,
	input  logic [NODE_W-1:0] to_node,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [NODE_W-1:0] visited_node,
	output logic              last
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_WR,
		ST_POP,
		ST_ROW,
		ST_SCAN,
		ST_EMIT,
		ST_PUSH
	} state_t;

	state_t                 state_q;
	logic [NODE_W-1:0]      node_count_q;
	logic [MAX_NODES-1:0]   row_vld_q;      // row holds written data; else reads as zero
	logic [MAX_NODES-1:0]   visited_q;
	logic [DEPTH_W-1:0]     depth_q;
	logic [MAX_NODES-1:0]   succ_q;         // successors still to push
	logic [NODE_W-1:0]      cur_q;          // node popped this round
	logic [IDX_W-1:0]       add_idx_q;
	logic [MAX_NODES-1:0]   add_mask_q;
	logic                   out_valid_q;
	logic [NODE_W-1:0]      visited_node_q;
	logic                   last_q;

	// memories
	logic [MAX_NODES-1:0]   adj_mem [MAX_NODES];
	logic [NODE_W-1:0]      stk_mem [MAX_NODES];
	logic [MAX_NODES-1:0]   adj_rd_s1;
	logic                   adj_vld_s1;
	logic [NODE_W-1:0]      stk_rd_s1;

	logic                   accept;
	logic                   from_ok;
	logic                   to_ok;
	logic [NODE_W-1:0]      from_m1;
	logic [NODE_W-1:0]      to_m1;
	logic [NODE_W-1:0]      cur_m1;
	logic [DEPTH_W-1:0]     depth_m1;
	logic [MAX_NODES-1:0]   rng_mask;
	logic [MAX_NODES-1:0]   row_eff;
	logic [MAX_NODES-1:0]   succ_new;
	logic [MAX_NODES-1:0]   succ_rest;
	logic [IDX_W-1:0]       push_idx;
	logic                   out_free;

	logic [IDX_W-1:0]       adj_raddr;
	logic                   adj_we;
	logic [MAX_NODES-1:0]   adj_wdata;
	logic [IDX_W-1:0]       stk_raddr;
	logic                   stk_we;
	logic [IDX_W-1:0]       stk_waddr;
	logic [NODE_W-1:0]      stk_wdata;

	assign in_ready     = (state_q == ST_IDLE);
	assign accept       = in_valid && in_ready;
	assign out_valid    = out_valid_q;
	assign visited_node = visited_node_q;
	assign last         = last_q;
	assign out_free     = !out_valid_q || out_ready;

	assign from_ok  = (from_node != '0) && (from_node <= node_count_q);
	assign to_ok    = (to_node != '0) && (to_node <= node_count_q);
	assign from_m1  = from_node - NODE_W'(1);
	assign to_m1    = to_node - NODE_W'(1);
	assign cur_m1   = stk_rd_s1 - NODE_W'(1);
	assign depth_m1 = depth_q - DEPTH_W'(1);

	// nodes above node_count are never followed
	always_comb begin
		for (int i = 0; i < MAX_NODES; i++) begin
			rng_mask[i] = (NODE_W'(i) < node_count_q);
		end
	end

	assign row_eff   = adj_vld_s1 ? adj_rd_s1 : '0;
	assign succ_new  = row_eff & ~visited_q & rng_mask;
	assign succ_rest = succ_q & (succ_q - MAX_NODES'(1));   // drop lowest set bit
	assign push_idx  = low_index(succ_q);

	// memory port control
	always_comb begin
		adj_raddr = (state_q == ST_ROW) ? cur_m1[IDX_W-1:0] : from_m1[IDX_W-1:0];
		adj_we    = (state_q == ST_ADD_WR);
		adj_wdata = row_eff | add_mask_q;
		stk_raddr = depth_m1[IDX_W-1:0];
		stk_we    = 1'b0;
		stk_waddr = depth_q[IDX_W-1:0];
		stk_wdata = NODE_W'(push_idx) + NODE_W'(1);
		if (accept && operation == OP_TRAVERSE && from_ok) begin
			stk_we    = 1'b1;
			stk_waddr = '0;
			stk_wdata = from_node;
		end else if (state_q == ST_PUSH) begin
			stk_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adj_we) begin
			adj_mem[add_idx_q] <= adj_wdata;
		end
		adj_rd_s1  <= adj_mem[adj_raddr];
		adj_vld_s1 <= row_vld_q[adj_raddr];
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
		stk_rd_s1 <= stk_mem[stk_raddr];
	end

	// sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			node_count_q   <= NODE_W'(MAX_NODES);
			row_vld_q      <= '0;
			visited_q      <= '0;
			depth_q        <= '0;
			succ_q         <= '0;
			cur_q          <= '0;
			add_idx_q      <= '0;
			add_mask_q     <= '0;
			out_valid_q    <= 1'b0;
			visited_node_q <= '0;
			last_q         <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				node_count_q <= (cfg_wr_data > NODE_W'(MAX_NODES)) ?
					NODE_W'(MAX_NODES) : cfg_wr_data;
			end
			// the emit step reloads the output register itself
			if (out_valid_q && out_ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (operation)
							OP_ADD: begin
								if (from_ok && to_ok) begin
									add_idx_q  <= from_m1[IDX_W-1:0];
									add_mask_q <= MAX_NODES'(1) << to_m1[IDX_W-1:0];
									state_q    <= ST_ADD_WR;
								end
							end
							OP_TRAVERSE: begin
								if (from_ok) begin
									visited_q <= MAX_NODES'(1) << from_m1[IDX_W-1:0];
									depth_q   <= DEPTH_W'(1);
									state_q   <= ST_POP;
								end else begin
									visited_q <= '0;
								end
							end
							OP_CLEAR: begin
								row_vld_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_ADD_WR: begin
					row_vld_q[add_idx_q] <= 1'b1;
					state_q              <= ST_IDLE;
				end
				ST_POP: begin
					depth_q <= depth_m1;
					state_q <= ST_ROW;
				end
				ST_ROW: begin
					cur_q   <= stk_rd_s1;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					// every successor is marked now; all get pushed before the next pop
					succ_q    <= succ_new;
					visited_q <= visited_q | succ_new;
					state_q   <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q    <= 1'b1;
						visited_node_q <= cur_q;
						last_q         <= (depth_q == '0) && (succ_q == '0);
						if (succ_q != '0) begin
							state_q <= ST_PUSH;
						end else if (depth_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_POP;
						end
					end
				end
				ST_PUSH: begin
					depth_q <= depth_q + DEPTH_W'(1);
					succ_q  <= succ_rest;
					if (succ_rest == '0) begin
						state_q <= ST_POP;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(MAX_NODES))
		else $error("node stack overfilled");

	a_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUSH) |-> (succ_q != '0))
		else $error("push with no successor pending");

	a_popped_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROW) |-> (stk_rd_s1 != '0 && stk_rd_s1 <= NODE_W'(MAX_NODES)))
		else $error("popped node out of range");

	a_end_flags_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && $past(state_q) == ST_EMIT) |-> (out_valid_q && last_q))
		else $error("traversal ended without last flag");
`endif

endmodule
